// ===== rtl/core/graph_bfs_eccentricity_assert.svh =====
// Assertion macros used by graph_bfs_eccentricity.sv.
`ifndef GRAPH_BFS_ECCENTRICITY_ASSERT_SVH
`define GRAPH_BFS_ECCENTRICITY_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define GBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define GBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gbe_pkg.sv =====
package gbe_pkg;

  // Graph size and derived widths
  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int FIELD_W   = 6;
  localparam int DIST_W    = 6;
  localparam int LEVEL_W   = 7;
  localparam int DIST_MAX  = 63;
  localparam int LEVEL_MAX = 127;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_WR_B,
    ST_INIT,
    ST_SCAN,
    ST_LEVEL
  } state_e;

  typedef logic [MAX_NODES-1:0] row_t;

endpackage

// ===== rtl/core/gbe_ram.sv =====
module gbe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one row, read one row with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/graph_bfs_eccentricity.sv =====
// Each input beat adds one undirected edge to a 64-node graph held as an adjacency
// bit matrix (empty after reset), then runs a level-by-level breadth-first search
// from node 0 and returns the largest hop distance to any reachable node (0 when
// node 0 has no neighbors, saturating at 63). Self-loops and out-of-range nodes add
// no edge but still return a result. The time until a beat's result is ready grows
// with the number of nodes reachable from node 0 and with the largest hop distance
// found, and is made up as follows:
// - every frontier node costs one read of its adjacency row through the single read
//   port of the row memory;
// - each search pass adds the return of the last row, an empty check and a level step;
// - the edge update reads row a, writes it while reading row b and then writes row b,
//   or only reads row a when no edge is stored;
// - the ST_INIT state sets up the search.
// The input is not ready while a search runs. The result waits in an output register,
// so the next beat may be taken before the previous result is consumed. Row valid bits
// stand in for a clearing pass.
module graph_bfs_eccentricity (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [5:0] first_node, [11:6] second_node
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // [5:0] farthest_distance
);
  import gbe_pkg::*;

  state_e state_q, state_d;

  logic [FIELD_W-1:0] a_q, a_d, b_q, b_d;
  row_t               visited_q, visited_d;
  row_t               pend_q, pend_d;
  row_t               next_q, next_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               inflight_q, inflight_d;
  logic               vld_rd_q, vld_rd_d;
  logic [MAX_NODES-1:0] row_vld_q, row_vld_d;
  logic               out_vld_q, out_vld_d;
  logic [DIST_W-1:0]  out_dist_q, out_dist_d;

  logic [NODE_W-1:0]  raddr;
  logic               we;
  logic [NODE_W-1:0]  waddr;
  row_t               wdata;
  row_t               rdata;
  row_t               row_eff;
  row_t               pick_onehot;
  logic [NODE_W-1:0]  pick_idx;
  row_t               fresh;
  logic               edge_ok;
  logic [NODE_W-1:0]  a_idx, b_idx;
  logic               out_free;

  gbe_ram #(
    .WIDTH(MAX_NODES),
    .DEPTH(MAX_NODES)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Decode the edge ends
  assign a_idx   = NODE_W'(a_q);
  assign b_idx   = NODE_W'(b_q);
  assign edge_ok = (a_q != b_q) && (32'(a_q) < MAX_NODES) && (32'(b_q) < MAX_NODES);

  // Drop row contents that were never written since reset
  assign row_eff = vld_rd_q ? rdata : '0;

  // Pick the lowest pending frontier node
  always_comb begin
    pick_onehot = pend_q & (~pend_q + row_t'(1));
    pick_idx    = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (pick_onehot[i]) begin
        pick_idx = pick_idx | NODE_W'(i);
      end
    end
  end

  assign fresh    = next_q & ~visited_q;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    visited_d  = visited_q;
    pend_d     = pend_q;
    next_d     = next_q;
    level_d    = level_q;
    inflight_d = 1'b0;
    row_vld_d  = row_vld_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_dist_d = out_dist_q;
    raddr      = pick_idx;
    we         = 1'b0;
    waddr      = a_idx;
    wdata      = row_eff;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          a_d     = s_axis_tdata_i[FIELD_W-1:0];
          b_d     = s_axis_tdata_i[2*FIELD_W-1:FIELD_W];
          state_d = ST_ADD_RD_A;
        end
      end
      ST_ADD_RD_A: begin
        raddr   = a_idx;
        state_d = edge_ok ? ST_ADD_WR_A : ST_INIT;
      end
      ST_ADD_WR_A: begin
        we               = 1'b1;
        waddr            = a_idx;
        wdata            = row_eff | (row_t'(1) << b_idx);
        row_vld_d[a_idx] = 1'b1;
        raddr            = b_idx;
        state_d          = ST_ADD_WR_B;
      end
      ST_ADD_WR_B: begin
        we               = 1'b1;
        waddr            = b_idx;
        wdata            = row_eff | (row_t'(1) << a_idx);
        row_vld_d[b_idx] = 1'b1;
        state_d          = ST_INIT;
      end
      ST_INIT: begin
        visited_d = row_t'(1);
        pend_d    = row_t'(1);
        next_d    = '0;
        level_d   = '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        // Issue one row read per frontier node, fold returning rows
        if (inflight_q) begin
          next_d = next_q | row_eff;
        end
        if (pend_q != '0) begin
          pend_d     = pend_q & ~pick_onehot;
          inflight_d = 1'b1;
        end else if (!inflight_q) begin
          state_d = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        if (fresh == '0) begin
          // Hold until the output register is free
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_dist_d = (32'(level_q) > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(level_q);
            state_d    = ST_IDLE;
          end
        end else begin
          visited_d = visited_q | fresh;
          pend_d    = fresh;
          next_d    = '0;
          level_d   = (32'(level_q) >= LEVEL_MAX) ? level_q : level_q + LEVEL_W'(1);
          state_d   = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    vld_rd_d = row_vld_q[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      inflight_q <= 1'b0;
      vld_rd_q   <= 1'b0;
      row_vld_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      inflight_q <= inflight_d;
      vld_rd_q   <= vld_rd_d;
      row_vld_q  <= row_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    visited_q  <= visited_d;
    pend_q     <= pend_d;
    next_q     <= next_d;
    level_q    <= level_d;
    out_dist_q <= out_dist_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(8-DIST_W){1'b0}}, out_dist_q};

  // Checks
  `include "graph_bfs_eccentricity_assert.svh"

  `GBE_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input ready right after a beat")
  `GBE_ASSERT_NOW(a_inflight_in_scan, inflight_q, state_q == ST_SCAN, "row read in flight outside scan")
  `GBE_ASSERT_NOW(a_root_visited, state_q == ST_SCAN, visited_q[0], "node 0 not visited during scan")
  `GBE_ASSERT_NOW(a_frontier_visited, state_q == ST_SCAN, (pend_q & ~visited_q) == '0, "frontier node not marked visited")

endmodule

// ===== verif/graph_bfs_eccentricity_test.sv =====
module graph_bfs_eccentricity_test;
  import gbe_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 9;
  // one search costs a row read per reachable node, at most 64, plus the level steps
  localparam int SEARCH_DRAIN   = 300;
  localparam int HOLDOFF_CYCLES = 800;
  localparam int STALL_LIMIT    = 5000;
  localparam int MAX_GAP        = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [5:0] first_node, [11:6] second_node
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [5:0] farthest_distance

  // shadow graph and pending distances
  row_t              graph_rows [MAX_NODES];
  logic [DIST_W-1:0] expected_distances [$];
  logic [FIELD_W-1:0] sent_first [$];
  logic [FIELD_W-1:0] sent_second [$];

  int unsigned error_count;
  int unsigned idle_cycles;
  bit          gaps_enabled;
  bit          holdoff_request;

  graph_bfs_eccentricity dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Store an undirected edge; drop self-loops and indexes past the graph
  function automatic void add_edge_to_graph(input logic [FIELD_W-1:0] node_a,
                                            input logic [FIELD_W-1:0] node_b);
    if (node_a != node_b && int'(node_a) < MAX_NODES && int'(node_b) < MAX_NODES) begin
      graph_rows[node_a][node_b] = 1'b1;
      graph_rows[node_b][node_a] = 1'b1;
    end
  endfunction

  // Level-by-level search from node 0; the hop count of the last level reached
  function automatic logic [DIST_W-1:0] farthest_distance_from_root();
    row_t        reached;
    row_t        frontier;
    row_t        next_level;
    int unsigned depth;
    reached  = row_t'(1);
    frontier = row_t'(1);
    depth    = 0;
    for (int lvl = 0; lvl <= MAX_NODES; lvl++) begin
      next_level = '0;
      for (int v = 0; v < MAX_NODES; v++) begin
        if (frontier[v]) next_level |= graph_rows[v];
      end
      next_level &= ~reached;
      if (next_level == '0) break;
      depth++;
      reached  |= next_level;
      frontier  = next_level;
    end
    return (depth > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(depth);
  endfunction

  // Offer one edge beat, hold it until taken, then predict its distance
  task automatic send_edge(input logic [FIELD_W-1:0] first_node,
                           input logic [FIELD_W-1:0] second_node);
    int unsigned gap;
    gap = gaps_enabled ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, second_node, first_node};
    do @(posedge clk_i); while (!s_axis_tready_o);
    add_edge_to_graph(first_node, second_node);
    expected_distances = {expected_distances, farthest_distance_from_root()};
    sent_first         = {sent_first, first_node};
    sent_second        = {sent_second, second_node};
  endtask

  // Edge between nodes whose indexes differ by two to four, in either order
  task automatic send_local_chord();
    int unsigned node_a;
    int unsigned span;
    int unsigned node_b;
    node_a = $urandom_range(0, MAX_NODES - 1);
    span   = $urandom_range(2, 4);
    node_b = (node_a + span < MAX_NODES) ? node_a + span : node_a - span;
    if ($urandom_range(0, 1)) send_edge(FIELD_W'(node_a), FIELD_W'(node_b));
    else send_edge(FIELD_W'(node_b), FIELD_W'(node_a));
  endtask

  // Self-loops and an edge far from the root leave the distance at zero
  task automatic test_isolated_edges();
    send_edge(6'd0, 6'd0);
    send_edge(6'd63, 6'd63);
    send_edge(6'd62, 6'd63);
    send_edge(6'd63, 6'd62);
    send_edge(6'd0, 6'd0);
  endtask

  // First edges at the root, duplicates in both orders
  task automatic test_root_edges();
    send_edge(6'd0, 6'd1);
    send_edge(6'd1, 6'd0);
    send_edge(6'd1, 6'd1);
    send_edge(6'd1, 6'd2);
    send_edge(6'd2, 6'd1);
    send_edge(6'd0, 6'd1);
  endtask

  // Extend a single chain out to the last node: the deepest search there is
  task automatic test_long_path();
    gaps_enabled = 1'b0;
    for (int i = 2; i < MAX_NODES - 1; i++) begin
      if (i == 30) gaps_enabled = 1'b1;
      if ($urandom_range(0, 1)) send_edge(FIELD_W'(i), FIELD_W'(i + 1));
      else send_edge(FIELD_W'(i + 1), FIELD_W'(i));
    end
  endtask

  // Hold off the result side while beats keep coming, so the input stalls
  task automatic test_result_backpressure();
    gaps_enabled    = 1'b0;
    holdoff_request = 1'b1;
    repeat (12) send_local_chord();
    gaps_enabled = 1'b1;
  endtask

  // Short chords keep distances in the middle range for a long while
  task automatic test_local_chords();
    for (int i = 0; i < 380; i++) begin
      if (i % 100 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
      send_local_chord();
    end
  endtask

  // Uniform edges mixed with self-loops and repeats of earlier edges
  task automatic test_random_edges();
    int unsigned kind;
    int unsigned pick;
    logic [FIELD_W-1:0] node_a;
    for (int i = 0; i < 950; i++) begin
      if (i % 120 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        node_a = FIELD_W'($urandom_range(0, 63));
        send_edge(node_a, node_a);
      end else if (kind == 1) begin
        pick = $urandom_range(0, sent_first.size() - 1);
        send_edge(sent_second[pick], sent_first[pick]);
      end else begin
        send_edge(FIELD_W'($urandom_range(0, 63)), FIELD_W'($urandom_range(0, 63)));
      end
    end
  endtask

  // Result side: random ready gaps, one long hold-off on request
  initial begin
    int unsigned gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        repeat (HOLDOFF_CYCLES) begin
          @(negedge clk_i);
          m_axis_tready_i <= 1'b0;
        end
      end
      gap = gaps_enabled ? $urandom_range(0, MAX_GAP) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_distances.size() == 0) begin
        $error("farthest_distance: no result expected, got %0d",
               m_axis_tdata_o[DIST_W-1:0]);
        error_count++;
      end else begin
        if (m_axis_tdata_o[DIST_W-1:0] !== expected_distances[0]) begin
          $error("farthest_distance: expected %0d, got %0d",
                 expected_distances[0], m_axis_tdata_o[DIST_W-1:0]);
          error_count++;
        end
        void'(expected_distances.pop_front());
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("graph_bfs_eccentricity_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    error_count     = 0;
    idle_cycles     = 0;
    gaps_enabled    = 1'b1;
    holdoff_request = 1'b0;
    for (int v = 0; v < MAX_NODES; v++) graph_rows[v] = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_isolated_edges();
    test_root_edges();
    test_long_path();
    test_result_backpressure();
    test_local_chords();
    test_random_edges();

    // drain outstanding searches
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_distances.size() != 0) @(posedge clk_i);
    repeat (SEARCH_DRAIN) @(posedge clk_i);
    if (error_count == 0) begin
      $display("graph_bfs_eccentricity_test OK");
    end else begin
      $display("graph_bfs_eccentricity_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gbe_pkg.sv
rtl/core/gbe_ram.sv
rtl/core/graph_bfs_eccentricity.sv
verif/graph_bfs_eccentricity_test.sv
